FILE: hdl/smacc_pkg.sv
// ----------------------------------------------------------------------------
// Sparse matrix accumulator package
// Field widths, status and action codes, register indexes and the result
// record shared by the control path and the top level.
// ----------------------------------------------------------------------------
package smacc_pkg;

	localparam int DEF_MAX_ROWS = 32;
	localparam int DEF_MAX_COLS = 32;

	localparam int CELL_W    = 32;
	localparam int IDX_W     = 6;
	localparam int STATUS_W  = 3;
	localparam int COUNT_W   = 11;
	localparam int CFG_IDX_W = 2;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 56;

	localparam logic [IDX_W-1:0] ROWS_RESET = 6'd32;
	localparam logic [IDX_W-1:0] COLS_RESET = 6'd32;

	localparam logic ACT_ACCUM = 1'b0;
	localparam logic ACT_SCAN  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

	localparam logic [STATUS_W-1:0] ST_STORED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ZEROED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ENTRY  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DONE   = 3'd4;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [IDX_W-1:0]      out_row;
		logic [IDX_W-1:0]      out_col;
		logic signed [CELL_W-1:0] out_value;
		logic [COUNT_W-1:0]    nonzero_total;
	} result_t;

endpackage

FILE: hdl/sparse_matrix_accumulator.sv
// Accumulate and out-of-range items load the output register from S_ACC or S_RANGE
// once it is free; an accumulate reads the cell memory, then writes it back, and no
// item is taken until it is through. Scan: each cell examined takes S_SCAN_RD and
// S_SCAN_CHK, and a row is left early when fewer than MAX_COLS columns are used.
// Reset: arst_n clears control state, then a clearing pass over all MAX_ROWS*MAX_COLS
// cells (1024 by default) zeroes the cell memory; items are held off until it ends.
// ----------------------------------------------------------------------------
// Sparse matrix accumulator
// Dense cell memory with triplet accumulate, nonzero count and row-major scan.
// Configuration writes are taken at any time, including during the clearing pass.
// ----------------------------------------------------------------------------
module sparse_matrix_accumulator #(
	parameter int MAX_ROWS = smacc_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = smacc_pkg::DEF_MAX_COLS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [smacc_pkg::S_TDATA_W-1:0]     s_tdata,   // row_index, col_index, addend
	input  logic [0:0]                          s_tuser,   // action
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [smacc_pkg::M_TDATA_W-1:0]     m_tdata,   // out_row, out_col, out_value,
	                                                       // nonzero_total
	output logic [smacc_pkg::STATUS_W-1:0]      m_tuser,   // status
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [smacc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [smacc_pkg::IDX_W-1:0]         cfg_data
);
	import smacc_pkg::*;

	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

	logic [IDX_W-1:0]  rows_q, cols_q;
	logic [IDX_W-1:0]  rows_eff, cols_eff;
	result_t           res;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [CELL_W-1:0] mem_wdata, mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROWS: rows_q <= cfg_data;
				REG_COLS: cols_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign rows_eff = (int'(rows_q) > MAX_ROWS) ? IDX_W'(MAX_ROWS) : rows_q;
	assign cols_eff = (int'(cols_q) > MAX_COLS) ? IDX_W'(MAX_COLS) : cols_q;

	smacc_ctrl #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.action(s_tuser[0]),
		.row_index(s_tdata[5:0]),
		.col_index(s_tdata[11:6]),
		.addend(s_tdata[43:12]),
		.rows_eff(rows_eff),
		.cols_eff(cols_eff),
		.out_res(res),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	smacc_cell_mem #(
		.DEPTH(CELLS),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign m_tuser = res.status;
	assign m_tdata = {1'b0, res.nonzero_total, res.out_value, res.out_col, res.out_row};

endmodule

FILE: hdl/smacc_cell_mem.sv
// ----------------------------------------------------------------------------
// Cell memory
// Single-write, single-read synchronous RAM holding one 32-bit cell per entry;
// read data is registered.
// ----------------------------------------------------------------------------
module smacc_cell_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [AW-1:0]                   waddr,
	input  logic [smacc_pkg::CELL_W-1:0]    wdata,
	input  logic                            re,
	input  logic [AW-1:0]                   raddr,
	output logic [smacc_pkg::CELL_W-1:0]    rdata
);
	import smacc_pkg::*;

	logic [CELL_W-1:0] mem [DEPTH];
	logic [CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/smacc_ctrl.sv
// ----------------------------------------------------------------------------
// Accumulate and scan control
// Clearing pass, read-modify-write of one cell per accumulate, row-major scan
// over the cell memory, nonzero count and the output register.
// ----------------------------------------------------------------------------
module smacc_ctrl #(
	parameter int MAX_ROWS = smacc_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = smacc_pkg::DEF_MAX_COLS,
	parameter int AW       = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              action,
	input  logic [smacc_pkg::IDX_W-1:0]       row_index,
	input  logic [smacc_pkg::IDX_W-1:0]       col_index,
	input  logic signed [smacc_pkg::CELL_W-1:0] addend,
	input  logic [smacc_pkg::IDX_W-1:0]       rows_eff,
	input  logic [smacc_pkg::IDX_W-1:0]       cols_eff,
	output smacc_pkg::result_t                out_res,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              mem_we,
	output logic [AW-1:0]                     mem_waddr,
	output logic [smacc_pkg::CELL_W-1:0]      mem_wdata,
	output logic                              mem_re,
	output logic [AW-1:0]                     mem_raddr,
	input  logic [smacc_pkg::CELL_W-1:0]      mem_rdata
);
	import smacc_pkg::*;

	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int RW    = $clog2(MAX_ROWS + 1);
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	localparam logic [2:0] S_CLEAR    = 3'd0;
	localparam logic [2:0] S_IDLE     = 3'd1;
	localparam logic [2:0] S_ACC      = 3'd2;
	localparam logic [2:0] S_RANGE    = 3'd3;
	localparam logic [2:0] S_SCAN_RD  = 3'd4;
	localparam logic [2:0] S_SCAN_CHK = 3'd5;

	logic [2:0]        state_q, state_d;
	logic [AW-1:0]     clr_q, clr_d;
	logic [RW-1:0]     srow_q, srow_d;
	logic [CW-1:0]     scol_q, scol_d;
	logic [COUNT_W-1:0] count_q, count_d;
	result_t           out_q, out_d;
	logic              out_valid_q, out_valid_d;
	logic              out_load;
	logic [IDX_W-1:0]  row_q, col_q;
	logic [CELL_W-1:0] addend_q;
	logic [AW-1:0]     addr_q, addr_d;
	logic              out_free, in_range, accept;
	logic [AW-1:0]     acc_addr, scan_addr;
	logic [CELL_W-1:0] sum;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign in_range  = (row_index != '0) && (col_index != '0) &&
		(row_index <= rows_eff) && (col_index <= cols_eff);
	assign acc_addr  = AW'((int'(row_index) - 1) * MAX_COLS + int'(col_index) - 1);
	assign scan_addr = AW'(int'(srow_q) * MAX_COLS + int'(scol_q));
	assign sum       = mem_rdata + addend_q;

	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		srow_d      = srow_q;
		scol_d      = scol_q;
		count_d     = count_q;
		addr_d      = addr_q;
		out_d       = out_q;
		out_load    = 1'b0;
		out_valid_d = out_valid_q && !out_ready;
		mem_we      = 1'b0;
		mem_waddr   = addr_q;
		mem_wdata   = sum;
		mem_re      = 1'b0;
		mem_raddr   = scan_addr;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == AW'(CELLS - 1)) begin
					state_d = S_IDLE;
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (action == ACT_SCAN) begin
						state_d = S_SCAN_RD;
					end else if (in_range) begin
						mem_re    = 1'b1;
						mem_raddr = acc_addr;
						addr_d    = acc_addr;
						state_d   = S_ACC;
					end else begin
						state_d = S_RANGE;
					end
				end
			end
			S_ACC: begin
				if (out_free) begin
					mem_we = 1'b1;
					if (mem_rdata == '0 && sum != '0) begin
						count_d = count_q + 1'b1;
					end else if (mem_rdata != '0 && sum == '0) begin
						count_d = count_q - 1'b1;
					end
					out_load            = 1'b1;
					out_d.status        = (sum == '0) ? ST_ZEROED : ST_STORED;
					out_d.out_row       = row_q;
					out_d.out_col       = col_q;
					out_d.out_value     = sum;
					out_d.nonzero_total = count_d;
					state_d             = S_IDLE;
				end
			end
			S_RANGE: begin
				if (out_free) begin
					out_load            = 1'b1;
					out_d.status        = ST_RANGE;
					out_d.out_row       = '0;
					out_d.out_col       = '0;
					out_d.out_value     = '0;
					out_d.nonzero_total = count_q;
					state_d             = S_IDLE;
				end
			end
			S_SCAN_RD: begin
				if (int'(srow_q) >= int'(rows_eff)) begin
					if (out_free) begin
						out_load            = 1'b1;
						out_d.status        = ST_DONE;
						out_d.out_row       = '0;
						out_d.out_col       = '0;
						out_d.out_value     = '0;
						out_d.nonzero_total = count_q;
						srow_d              = '0;
						scol_d              = '0;
						state_d             = S_IDLE;
					end
				end else if (int'(scol_q) >= int'(cols_eff)) begin
					srow_d = srow_q + 1'b1;
					scol_d = '0;
				end else begin
					mem_re  = 1'b1;
					state_d = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				if (mem_rdata == '0 || out_free) begin
					if (int'(scol_q) == MAX_COLS - 1) begin
						scol_d = '0;
						srow_d = srow_q + 1'b1;
					end else begin
						scol_d = scol_q + 1'b1;
					end
					if (mem_rdata != '0) begin
						out_load            = 1'b1;
						out_d.status        = ST_ENTRY;
						out_d.out_row       = IDX_W'(int'(srow_q) + 1);
						out_d.out_col       = IDX_W'(int'(scol_q) + 1);
						out_d.out_value     = mem_rdata;
						out_d.nonzero_total = count_q;
						state_d             = S_IDLE;
					end else begin
						state_d = S_SCAN_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (out_load) begin
			out_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			srow_q      <= '0;
			scol_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			srow_q      <= srow_d;
			scol_q      <= scol_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		out_q  <= out_d;
		addr_q <= addr_d;
		if (accept) begin
			row_q    <= row_index;
			col_q    <= col_index;
			addend_q <= addend;
		end
	end

	assign out_res   = out_q;
	assign out_valid = out_valid_q;

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + 11'd1) ||
			(count_q == $past(count_q) - 11'd1))
		else $error("nonzero count moved by more than one");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_q))
		else $error("pending result overwritten");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("new transaction taken while one is in flight");

	a_done_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && out_d.status == ST_DONE |=> srow_q == '0 && scol_q == '0)
		else $error("scan pointer not rewound after done");

	a_no_read_while_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !mem_re && !out_load)
		else $error("activity during clearing pass");

endmodule

FILE: dv/sparse_matrix_accumulator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse matrix accumulator testbench
// Sends triplet and scan transactions with random gaps on both streams.
// A shadow matrix with its own count and scan pointer predicts each result
// that a directed item does not give; all are compared field by field. Matrix
// size settings range from empty to saturated and change only while idle.
// ----------------------------------------------------------------------------
module sparse_matrix_accumulator_tb;
	import smacc_pkg::*;

	localparam int ROWS           = DEF_MAX_ROWS;
	localparam int COLS           = DEF_MAX_COLS;
	localparam int CELLS          = ROWS * COLS;
	localparam int STALL_MAX      = 18;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int PHASES         = 14;
	localparam int PHASE_ITEMS    = 105;
	localparam int PAD_W          = S_TDATA_W - 2 * IDX_W - CELL_W;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef struct {
		logic              act;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [CELL_W-1:0] addend;
		bit                typed;
		result_t           res;
	} triplet_row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;   // row_index, col_index, addend
	logic [0:0]           s_tuser   = '0;   // action
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;          // out_row, out_col, out_value, nonzero_total
	logic [STATUS_W-1:0]  m_tuser;          // status
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [IDX_W-1:0]     cfg_data  = '0;

	logic [CELL_W-1:0] shadow_cells [CELLS];
	int unsigned       shadow_count = 0;
	int unsigned       shadow_ptr   = 0;
	logic [IDX_W-1:0]  shadow_rows  = ROWS_RESET;
	logic [IDX_W-1:0]  shadow_cols  = COLS_RESET;

	result_t      pending_results [$];
	triplet_row_t directed_rows [$];

	int phase_rows [PHASES] = '{1, 0, 5, 63, 4, 1, 32, 33, 7, 32, 0, 0, 0, 0};
	int phase_cols [PHASES] = '{1, 5, 0, 63, 4, 32, 1, 2, 3, 32, 0, 0, 0, 0};

	int errors = 0;
	int n_items = 0;
	int n_cfg = 0;
	int n_stored = 0;
	int n_zeroed = 0;
	int n_range = 0;
	int n_entry = 0;
	int n_done = 0;
	int idle_cycles = 0;
	bit s_quiet = 1'b0;
	bit r_quiet = 1'b0;
	bit hold_req = 1'b0;

	sparse_matrix_accumulator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int eff_size(input logic [IDX_W-1:0] used, input int limit);
		return (used > limit) ? limit : int'(used);
	endfunction

	// Apply one transaction to the shadow matrix and return its result.
	function automatic result_t matrix_update(input logic act, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [CELL_W-1:0] addend);
		result_t res;
		int nr;
		int nc;
		int idx;
		int p;
		bit found;
		logic [CELL_W-1:0] oldv;
		logic [CELL_W-1:0] newv;
		nr = eff_size(shadow_rows, ROWS);
		nc = eff_size(shadow_cols, COLS);
		res = '0;
		if (act == ACT_ACCUM) begin
			if (row == 0 || col == 0 || row > nr || col > nc) begin
				res.status = ST_RANGE;
			end else begin
				idx = (row - 1) * COLS + (col - 1);
				oldv = shadow_cells[idx];
				newv = oldv + addend;
				shadow_cells[idx] = newv;
				if (oldv == 0 && newv != 0)
					shadow_count++;
				else if (oldv != 0 && newv == 0)
					shadow_count--;
				res.status = (newv == 0) ? ST_ZEROED : ST_STORED;
				res.out_row = row;
				res.out_col = col;
				res.out_value = newv;
			end
		end else begin
			p = shadow_ptr;
			found = 1'b0;
			while (!found && p < CELLS && p / COLS < nr) begin
				if (p % COLS < nc && shadow_cells[p] != 0)
					found = 1'b1;
				else
					p++;
			end
			if (found) begin
				shadow_ptr = p + 1;
				res.status = ST_ENTRY;
				res.out_row = IDX_W'(p / COLS + 1);
				res.out_col = IDX_W'(p % COLS + 1);
				res.out_value = shadow_cells[p];
			end else begin
				shadow_ptr = 0;
				res.status = ST_DONE;
			end
		end
		res.nonzero_total = shadow_count[COUNT_W-1:0];
		return res;
	endfunction

	function automatic void add_row(input logic act, input int row, input int col,
			input logic [CELL_W-1:0] addend, input bit typed, input logic [STATUS_W-1:0] st,
			input int r, input int c, input logic [CELL_W-1:0] v, input int n);
		triplet_row_t t;
		t.act = act;
		t.row = IDX_W'(row);
		t.col = IDX_W'(col);
		t.addend = addend;
		t.typed = typed;
		t.res.status = st;
		t.res.out_row = IDX_W'(r);
		t.res.out_col = IDX_W'(c);
		t.res.out_value = v;
		t.res.nonzero_total = COUNT_W'(n);
		directed_rows.push_back(t);
	endfunction

	task automatic flag_mismatch(input string what, input logic [CELL_W-1:0] got_v,
			input logic [CELL_W-1:0] exp_v);
		errors++;
		$display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got_v, exp_v);
	endtask

	task automatic send_triplet(input logic act, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [CELL_W-1:0] addend, input bit typed,
			input result_t typed_res);
		int gap;
		result_t pred;
		if ($urandom_range(0, 39) == 0)
			s_quiet = !s_quiet;
		gap = s_quiet ? 0 : $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{PAD_W{1'b0}}, addend, col, row};
		s_tuser <= act;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pred = matrix_update(act, row, col, addend);
		pending_results.push_back(typed ? typed_res : pred);
		n_items++;
	endtask

	// Hold the input stream until every pending result is out.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IDX_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_ROWS)
			shadow_rows = data;
		else if (idx == REG_COLS)
			shadow_cols = data;
		n_cfg++;
		@(posedge clk);
	endtask

	task automatic run_size_phase(input logic [IDX_W-1:0] rows, input logic [IDX_W-1:0] cols,
			input int count, input bit press);
		int nr;
		int nc;
		int scan_pct;
		int r;
		int c;
		int idx;
		logic act;
		logic [CELL_W-1:0] add;
		drain_results();
		write_reg(REG_ROWS, rows);
		write_reg(REG_COLS, cols);
		write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, IDX_W'($urandom));
		nr = eff_size(rows, ROWS);
		nc = eff_size(cols, COLS);
		// keep scans rare on large matrices, where one can walk much of the matrix
		scan_pct = (nr * nc > 64) ? 3 : 20;
		s_quiet = press || ($urandom_range(0, 3) == 0);
		hold_req = press;
		repeat (count) begin
			act = ($urandom_range(0, 99) < scan_pct) ? ACT_SCAN : ACT_ACCUM;
			if (nr > 0 && $urandom_range(0, 9) != 0)
				r = $urandom_range(1, nr);
			else
				r = $urandom_range(0, 63);
			if (nc > 0 && $urandom_range(0, 9) != 0)
				c = $urandom_range(1, nc);
			else
				c = $urandom_range(0, 63);
			idx = (r > 0 && c > 0 && r <= ROWS && c <= COLS) ? (r - 1) * COLS + c - 1 : 0;
			case ($urandom_range(0, 9))
				0, 1, 2: add = $urandom_range(0, 6) - 3;
				3, 4:    add = -shadow_cells[idx];
				5:       add = 32'h7FFF_FFFF;
				6:       add = 32'h8000_0000;
				default: add = $urandom;
			endcase
			send_triplet(act, r[IDX_W-1:0], c[IDX_W-1:0], add, 1'b0, '0);
		end
	endtask

	// Count cycles with no transaction on any channel.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", idle_cycles);
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : result_sink
		int gap;
		result_t got;
		result_t want;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 49) == 0)
				r_quiet = !r_quiet;
			if (hold_req) begin
				hold_req = 1'b0;
				gap = LONG_HOLD;
			end else begin
				gap = r_quiet ? 0 : $urandom_range(0, STALL_MAX);
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			got.status = m_tuser;
			got.out_row = m_tdata[IDX_W-1:0];
			got.out_col = m_tdata[2*IDX_W-1:IDX_W];
			got.out_value = m_tdata[2*IDX_W+CELL_W-1:2*IDX_W];
			got.nonzero_total = m_tdata[2*IDX_W+CELL_W+COUNT_W-1:2*IDX_W+CELL_W];
			case (got.status)
				ST_STORED: n_stored++;
				ST_ZEROED: n_zeroed++;
				ST_RANGE:  n_range++;
				ST_ENTRY:  n_entry++;
				default:   n_done++;
			endcase
			if (pending_results.size() == 0) begin
				flag_mismatch("result with nothing pending", CELL_W'(got.status), '0);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status)
					flag_mismatch("status", CELL_W'(got.status), CELL_W'(want.status));
				if (got.out_row !== want.out_row)
					flag_mismatch("out_row", CELL_W'(got.out_row), CELL_W'(want.out_row));
				if (got.out_col !== want.out_col)
					flag_mismatch("out_col", CELL_W'(got.out_col), CELL_W'(want.out_col));
				if (got.out_value !== want.out_value)
					flag_mismatch("out_value", got.out_value, want.out_value);
				if (got.nonzero_total !== want.nonzero_total)
					flag_mismatch("nonzero_total", CELL_W'(got.nonzero_total),
						CELL_W'(want.nonzero_total));
			end
		end
	end

	initial begin : stimulus
		triplet_row_t t;
		for (int i = 0; i < CELLS; i++)
			shadow_cells[i] = '0;
		for (int i = PHASES - 4; i < PHASES; i++) begin
			phase_rows[i] = $urandom_range(1, 8);
			phase_cols[i] = $urandom_range(1, 8);
		end

		add_row(ACT_SCAN, 0, 0, 32'h0, 1, ST_DONE, 0, 0, 32'h0, 0);
		add_row(ACT_ACCUM, 0, 1, 32'h5, 1, ST_RANGE, 0, 0, 32'h0, 0);
		add_row(ACT_ACCUM, 1, 0, 32'h5, 1, ST_RANGE, 0, 0, 32'h0, 0);
		add_row(ACT_ACCUM, 33, 1, 32'h7, 1, ST_RANGE, 0, 0, 32'h0, 0);
		add_row(ACT_ACCUM, 1, 33, 32'h1, 1, ST_RANGE, 0, 0, 32'h0, 0);
		add_row(ACT_ACCUM, 63, 63, 32'hFFFF_FFFF, 1, ST_RANGE, 0, 0, 32'h0, 0);
		add_row(ACT_ACCUM, 1, 1, 32'h0, 1, ST_ZEROED, 1, 1, 32'h0, 0);
		add_row(ACT_ACCUM, 1, 1, 32'h7FFF_FFFF, 1, ST_STORED, 1, 1, 32'h7FFF_FFFF, 1);
		add_row(ACT_ACCUM, 1, 1, 32'h1, 1, ST_STORED, 1, 1, 32'h8000_0000, 1);
		add_row(ACT_ACCUM, 32, 32, 32'h8000_0000, 1, ST_STORED, 32, 32, 32'h8000_0000, 2);
		add_row(ACT_ACCUM, 32, 32, 32'h8000_0000, 1, ST_ZEROED, 32, 32, 32'h0, 1);
		add_row(ACT_ACCUM, 1, 32, 32'hFFFF_FFFF, 0, ST_STORED, 0, 0, 32'h0, 0);
		add_row(ACT_ACCUM, 32, 1, 32'h1, 0, ST_STORED, 0, 0, 32'h0, 0);
		add_row(ACT_SCAN, 63, 63, 32'hFFFF_FFFF, 0, ST_STORED, 0, 0, 32'h0, 0);
		add_row(ACT_SCAN, 0, 0, 32'h0, 0, ST_STORED, 0, 0, 32'h0, 0);
		add_row(ACT_SCAN, 0, 0, 32'h0, 0, ST_STORED, 0, 0, 32'h0, 0);
		add_row(ACT_SCAN, 0, 0, 32'h0, 0, ST_STORED, 0, 0, 32'h0, 0);
		add_row(ACT_SCAN, 0, 0, 32'h0, 0, ST_STORED, 0, 0, 32'h0, 0);
		add_row(ACT_ACCUM, 1, 1, 32'h8000_0000, 0, ST_STORED, 0, 0, 32'h0, 0);
		add_row(ACT_ACCUM, 16, 17, 32'h5555_5555, 0, ST_STORED, 0, 0, 32'h0, 0);
		add_row(ACT_ACCUM, 17, 16, 32'hAAAA_AAAA, 0, ST_STORED, 0, 0, 32'h0, 0);
		add_row(ACT_SCAN, 0, 0, 32'h0, 0, ST_STORED, 0, 0, 32'h0, 0);
		add_row(ACT_SCAN, 0, 0, 32'h0, 0, ST_STORED, 0, 0, 32'h0, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			t = directed_rows[i];
			send_triplet(t.act, t.row, t.col, t.addend, t.typed, t.res);
		end

		for (int ph = 0; ph < PHASES; ph++)
			run_size_phase(IDX_W'(phase_rows[ph]), IDX_W'(phase_cols[ph]),
				(phase_rows[ph] == 0 || phase_cols[ph] == 0) ? 40 : PHASE_ITEMS, ph == 4);

		drain_results();
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		$display("Run covered %0d transactions and %0d register writes over %0d size settings.",
			n_items, n_cfg, PHASES + 1);
		$display("Results: %0d stored, %0d zeroed, %0d out of range, %0d entries, %0d done.",
			n_stored, n_zeroed, n_range, n_entry, n_done);
		if (errors == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/smacc_pkg.sv
hdl/smacc_cell_mem.sv
hdl/smacc_ctrl.sv
hdl/sparse_matrix_accumulator.sv
dv/sparse_matrix_accumulator_tb.sv
